[src/alle_pkg.sv]
`default_nettype none

package alle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 3;

  localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_DATA  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_NODE = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NODE_FREE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_W2,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         node_index;
    logic signed [DATA_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [IDX_W-1:0]         node_out;
    logic signed [DATA_W-1:0] data_out;
    logic [IDX_W-1:0]         next_out;
    logic [IDX_W-1:0]         prev_out;
    logic                     node_in_use;
    logic [IDX_W-1:0]         head_out;
    logic [IDX_W-1:0]         tail_out;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic w2;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic two_phase;
  } dp_sts_t;

  // next link of a slot that has never been written: the initial free chain
  function automatic logic [IDX_W-1:0] rst_next(input logic [IDX_W-1:0] s);
    logic [IDX_W-1:0] r;
    if (s == IDX_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/alle_ctrl.sv]
`default_nettype none

module alle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire alle_pkg::dp_sts_t sts_i,
  output alle_pkg::ctl_cmd_t     cmd_o,
  output logic                   busy
);
  import alle_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts_i.two_phase) begin
          state_nxt = S_W2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_W2:   state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_r == S_IDLE) && start;
    cmd_o.rd   = (state_r == S_READ);
    cmd_o.exec = (state_r == S_EXEC);
    cmd_o.w2   = (state_r == S_W2);
    cmd_o.fin  = (state_r == S_FIN);
    busy       = (state_r != S_IDLE);
  end

`ifndef SYNTHESIS
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_READ))
    else $error("accepted item did not enter the read step");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !sts_i.two_phase) |=> (state_r == S_FIN))
    else $error("single-phase operation did not finish");
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.load, cmd_o.rd, cmd_o.exec, cmd_o.w2, cmd_o.fin}))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

[src/alle_dp.sv]
`default_nettype none

module alle_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire alle_pkg::ctl_cmd_t cmd_i,
  input  wire alle_pkg::in_item_t in_item_i,
  output alle_pkg::dp_sts_t      sts_o,
  output logic                   out_valid_o,
  output alle_pkg::out_item_t    out_item_o
);
  import alle_pkg::*;

  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [IDX_W-1:0]  next_mem [CAPACITY];
  logic [IDX_W-1:0]  prev_mem [CAPACITY];

  logic [OP_W-1:0]     op_r;
  logic [IDX_W-1:0]    idx_r;
  logic [DATA_W-1:0]   val_r;
  logic [IDX_W-1:0]    tgt_r;
  logic [IDX_W-1:0]    tgt_nxt;
  logic [IDX_W-1:0]    head_r;
  logic [IDX_W-1:0]    tail_r;
  logic [IDX_W-1:0]    free_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CAPACITY-1:0] nw_r;
  logic [CAPACITY-1:0] pw_r;

  logic [IDX_W-1:0]  nxa_q;
  logic [IDX_W-1:0]  nxf_q;
  logic [IDX_W-1:0]  pva_q;
  logic [DATA_W-1:0] dta_q;
  logic              nwa_q;
  logic              nwf_q;
  logic              pwa_q;

  logic [IDX_W-1:0] nxa;
  logic [IDX_W-1:0] pva;
  logic [IDX_W-1:0] nxf;
  logic             vld_a;
  logic             use_a;

  logic [IDX_W-1:0] nxa_r;
  logic [IDX_W-1:0] nxf_r;

  logic [STAT_W-1:0] rep_status_r;
  logic [IDX_W-1:0]  rep_node_r;
  logic [DATA_W-1:0] rep_data_r;
  logic [IDX_W-1:0]  rep_next_r;
  logic [IDX_W-1:0]  rep_prev_r;
  logic              rep_use_r;

  logic [STAT_W-1:0] rep_status_nxt;
  logic [IDX_W-1:0]  rep_node_nxt;
  logic [DATA_W-1:0] rep_data_nxt;
  logic [IDX_W-1:0]  rep_next_nxt;
  logic [IDX_W-1:0]  rep_prev_nxt;
  logic              rep_use_nxt;
  logic              two_phase;

  logic             nx_we;
  logic [IDX_W-1:0] nx_wa;
  logic [IDX_W-1:0] nx_wd;
  logic             pv_we;
  logic [IDX_W-1:0] pv_wa;
  logic [IDX_W-1:0] pv_wd;
  logic             dt_we;
  logic [IDX_W-1:0] dt_wa;
  logic             v_set;
  logic             v_clr;
  logic [IDX_W-1:0] v_wa;
  logic             free_we;
  logic [IDX_W-1:0] free_wd;

  logic              out_valid_r;
  out_item_t         out_item_r;

  always_comb begin
    if (op_r == OP_INS_FRONT) begin
      tgt_nxt = '0;
    end else if (op_r == OP_INS_BACK) begin
      tgt_nxt = tail_r;
    end else begin
      tgt_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r  <= in_item_i.operation;
      idx_r <= in_item_i.node_index;
      val_r <= in_item_i.value_in;
    end
    if (cmd_i.rd) begin
      tgt_r <= tgt_nxt;
      nxa_q <= next_mem[tgt_nxt];
      nxf_q <= next_mem[free_r];
      pva_q <= prev_mem[tgt_nxt];
      dta_q <= data_mem[tgt_nxt];
      nwa_q <= nw_r[tgt_nxt];
      nwf_q <= nw_r[free_r];
      pwa_q <= pw_r[tgt_nxt];
    end
    if (cmd_i.exec) begin
      nxa_r        <= nxa;
      nxf_r        <= nxf;
      rep_status_r <= rep_status_nxt;
      rep_node_r   <= rep_node_nxt;
      rep_data_r   <= rep_data_nxt;
      rep_next_r   <= rep_next_nxt;
      rep_prev_r   <= rep_prev_nxt;
      rep_use_r    <= rep_use_nxt;
    end
    if (cmd_i.fin) begin
      out_item_r.status      <= rep_status_r;
      out_item_r.node_out    <= rep_node_r;
      out_item_r.data_out    <= rep_data_r;
      out_item_r.next_out    <= rep_next_r;
      out_item_r.prev_out    <= rep_prev_r;
      out_item_r.node_in_use <= rep_use_r;
      out_item_r.head_out    <= head_r;
      out_item_r.tail_out    <= tail_r;
    end
  end

  // slot 0 lives in head_r and tail_r; unwritten slots read as the initial chain
  always_comb begin
    if (tgt_r == '0) begin
      nxa = head_r;
      pva = tail_r;
    end else begin
      nxa = nwa_q ? nxa_q : rst_next(tgt_r);
      pva = pwa_q ? pva_q : '0;
    end
    nxf   = nwf_q ? nxf_q : rst_next(free_r);
    vld_a = valid_r[tgt_r];
    use_a = vld_a && (tgt_r != '0);
  end

  always_comb begin
    rep_status_nxt = ST_OK;
    rep_node_nxt   = tgt_r;
    rep_data_nxt   = use_a ? dta_q : '0;
    rep_next_nxt   = nxa;
    rep_prev_nxt   = pva;
    rep_use_nxt    = use_a;
    two_phase      = 1'b0;
    nx_we   = 1'b0;
    nx_wa   = tgt_r;
    nx_wd   = free_r;
    pv_we   = 1'b0;
    pv_wa   = tgt_r;
    pv_wd   = '0;
    dt_we   = 1'b0;
    dt_wa   = tgt_r;
    v_set   = 1'b0;
    v_clr   = 1'b0;
    v_wa    = tgt_r;
    free_we = 1'b0;
    free_wd = nxf_r;

    unique case (op_r)
      OP_INS_AFTER, OP_INS_FRONT, OP_INS_BACK: begin
        priority if (!vld_a) begin
          rep_status_nxt = ST_BAD_INDEX;
        end else if (free_r == '0) begin
          rep_status_nxt = ST_FULL;
        end else begin
          two_phase    = 1'b1;
          rep_node_nxt = free_r;
          rep_data_nxt = val_r;
          rep_next_nxt = nxa;
          rep_prev_nxt = tgt_r;
          rep_use_nxt  = 1'b1;
          if (cmd_i.exec) begin
            nx_we = 1'b1;
            nx_wa = free_r;
            nx_wd = nxa;
            pv_we = 1'b1;
            pv_wa = free_r;
            pv_wd = tgt_r;
            dt_we = 1'b1;
            dt_wa = free_r;
            v_set = 1'b1;
            v_wa  = free_r;
          end
        end
        if (cmd_i.w2) begin
          nx_we   = 1'b1;
          nx_wa   = tgt_r;
          nx_wd   = free_r;
          pv_we   = 1'b1;
          pv_wa   = nxa_r;
          pv_wd   = free_r;
          free_we = 1'b1;
          free_wd = nxf_r;
        end
      end
      OP_DELETE: begin
        priority if (tgt_r == '0) begin
          rep_status_nxt = ST_BAD_INDEX;
        end else if (head_r == '0) begin
          rep_status_nxt = ST_EMPTY;
        end else if (!vld_a) begin
          rep_status_nxt = ST_NODE_FREE;
        end else begin
          two_phase    = 1'b1;
          rep_data_nxt = '0;
          rep_next_nxt = free_r;
          rep_prev_nxt = '0;
          rep_use_nxt  = 1'b0;
          if (cmd_i.exec) begin
            nx_we = 1'b1;
            nx_wa = pva;
            nx_wd = nxa;
            pv_we = 1'b1;
            pv_wa = nxa;
            pv_wd = pva;
          end
        end
        if (cmd_i.w2) begin
          nx_we   = 1'b1;
          nx_wa   = tgt_r;
          nx_wd   = free_r;
          pv_we   = 1'b1;
          pv_wa   = tgt_r;
          pv_wd   = '0;
          v_clr   = 1'b1;
          v_wa    = tgt_r;
          free_we = 1'b1;
          free_wd = tgt_r;
        end
      end
      OP_SET_DATA: begin
        if (!use_a) begin
          rep_status_nxt = ST_BAD_INDEX;
        end else begin
          rep_data_nxt = val_r;
          if (cmd_i.exec) begin
            dt_we = 1'b1;
            dt_wa = tgt_r;
          end
        end
      end
      OP_READ_NODE: begin
        rep_status_nxt = ST_OK;
      end
      default: begin
        rep_status_nxt = ST_BAD_INDEX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we && (nx_wa != '0)) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we && (pv_wa != '0)) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (dt_we) begin
      data_mem[dt_wa] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= IDX_W'(1);
      valid_r     <= CAPACITY'(1);
      nw_r        <= '0;
      pw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.fin;
      if (nx_we) begin
        if (nx_wa == '0) begin
          head_r <= nx_wd;
        end else begin
          nw_r[nx_wa] <= 1'b1;
        end
      end
      if (pv_we) begin
        if (pv_wa == '0) begin
          tail_r <= pv_wd;
        end else begin
          pw_r[pv_wa] <= 1'b1;
        end
      end
      if (v_set) begin
        valid_r[v_wa] <= 1'b1;
      end else if (v_clr) begin
        valid_r[v_wa] <= 1'b0;
      end
      if (free_we) begin
        free_r <= free_wd;
      end
    end
  end

  assign sts_o.two_phase = two_phase;
  assign out_valid_o     = out_valid_r;
  assign out_item_o      = out_item_r;

`ifndef SYNTHESIS
  a_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == '0) == (tail_r == '0))
    else $error("head and tail disagree on an empty list");
  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0])
    else $error("sentinel slot lost its valid bit");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd_i.w2 && (free_r != '0)) |-> !valid_r[free_r])
    else $error("free chain head holds list data");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire

[src/array_linked_list_engine.sv]
// Channel   Ports                         Handshake
// input     start, busy, in_item          taken when start high and busy low
// result    out_valid, out_item           one-cycle strobe per item, no back-pressure
//
// A successful insert or delete passes through one read of the link and data
// memories, then two write steps, since each link memory has a single write
// port. Every other item skips the second write step. The result strobe is
// high in the first cycle with busy low. Synchronous active-low reset restores
// the initial free chain with no clearing pass; no result is ever held off by
// the receiver.

`default_nettype none

module array_linked_list_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire alle_pkg::in_item_t in_item,
  output logic                    out_valid,
  output alle_pkg::out_item_t     out_item
);
  import alle_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  alle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy  (busy)
  );

  alle_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .in_item_i   (in_item),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

endmodule

`default_nettype wire

[sim/alle_checker.sv]
module alle_checker
  import alle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding
);

  logic signed [DATA_W-1:0] slot_data [CAPACITY];
  logic [IDX_W-1:0]         slot_next [CAPACITY];
  logic [IDX_W-1:0]         slot_prev [CAPACITY];
  logic                     slot_used [CAPACITY];
  logic [IDX_W-1:0]         free_slot;
  out_item_t                node_reports [$];

  task automatic clear_table();
    for (int i = 0; i < CAPACITY; i++) begin
      slot_data[i] = '0;
      slot_prev[i] = '0;
      slot_used[i] = (i == 0);
      slot_next[i] = (i == 0 || i == CAPACITY - 1) ? '0 : IDX_W'(i + 1);
    end
    free_slot = IDX_W'(1);
  endtask

  function automatic out_item_t node_view(input logic [STAT_W-1:0] st,
                                          input logic [IDX_W-1:0] s);
    out_item_t r;
    r.status      = st;
    r.node_out    = s;
    r.node_in_use = (s != 0) && slot_used[s];
    r.data_out    = r.node_in_use ? slot_data[s] : '0;
    r.next_out    = slot_next[s];
    r.prev_out    = slot_prev[s];
    r.head_out    = slot_next[0];
    r.tail_out    = slot_prev[0];
    return r;
  endfunction

  task automatic link_after(input logic [IDX_W-1:0] t, input logic signed [DATA_W-1:0] v,
                            output out_item_t r);
    logic [IDX_W-1:0] f;
    logic [IDX_W-1:0] nx;
    if (!slot_used[t]) begin
      r = node_view(ST_BAD_INDEX, t);
    end else if (free_slot == 0) begin
      r = node_view(ST_FULL, t);
    end else begin
      f            = free_slot;
      free_slot    = slot_next[f];
      nx           = slot_next[t];
      slot_data[f] = v;
      slot_next[f] = nx;
      slot_prev[f] = t;
      slot_used[f] = 1'b1;
      slot_prev[nx] = f;
      slot_next[t] = f;
      r = node_view(ST_OK, f);
    end
  endtask

  task automatic list_step(input in_item_t it, output out_item_t r);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    idx = it.node_index;
    case (it.operation)
      OP_INS_AFTER: link_after(idx, it.value_in, r);
      OP_INS_FRONT: link_after('0, it.value_in, r);
      OP_INS_BACK:  link_after(slot_prev[0], it.value_in, r);
      OP_DELETE: begin
        if (idx == 0) begin
          r = node_view(ST_BAD_INDEX, idx);
        end else if (slot_next[0] == 0) begin
          r = node_view(ST_EMPTY, idx);
        end else if (!slot_used[idx]) begin
          r = node_view(ST_NODE_FREE, idx);
        end else begin
          p              = slot_prev[idx];
          n              = slot_next[idx];
          slot_next[p]   = n;
          slot_prev[n]   = p;
          slot_next[idx] = free_slot;
          slot_prev[idx] = '0;
          slot_used[idx] = 1'b0;
          free_slot      = idx;
          r = node_view(ST_OK, idx);
        end
      end
      OP_SET_DATA: begin
        if (idx == 0 || !slot_used[idx]) begin
          r = node_view(ST_BAD_INDEX, idx);
        end else begin
          slot_data[idx] = it.value_in;
          r = node_view(ST_OK, idx);
        end
      end
      OP_READ_NODE: r = node_view(ST_OK, idx);
      default:      r = node_view(ST_BAD_INDEX, idx);
    endcase
  endtask

  task automatic check_field(input string fld, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, fld, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t r;
    if (!rst_n) begin
      clear_table();
      node_reports.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (node_reports.size() == 0) begin
          $display("%0t: result with no item pending, expected none actual %p",
                   $time, out_item);
          fail_count++;
        end else begin
          want = node_reports.pop_front();
          check_field("status", want.status, out_item.status);
          check_field("node_out", want.node_out, out_item.node_out);
          check_field("data_out", want.data_out, out_item.data_out);
          check_field("next_out", want.next_out, out_item.next_out);
          check_field("prev_out", want.prev_out, out_item.prev_out);
          check_field("node_in_use", want.node_in_use, out_item.node_in_use);
          check_field("head_out", want.head_out, out_item.head_out);
          check_field("tail_out", want.tail_out, out_item.tail_out);
        end
      end
      if (start && !busy) begin
        list_step(in_item, r);
        node_reports.push_back(r);
      end
    end
    outstanding <= node_reports.size();
  end

endmodule

[sim/tb_array_linked_list_engine.sv]
module tb_array_linked_list_engine;
  import alle_pkg::*;

  localparam int HALF      = 10;
  localparam int LIMIT     = 40000;
  localparam int N_RANDOM  = 400;

  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] D_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] D_MAX = 32'sh7FFF_FFFF;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_valid;
  out_item_t        out_item;
  int               fail_count;
  int               outstanding;
  int               cycles = 0;
  int               idle_pct;
  logic [CAPACITY-1:0] live_hint;

  array_linked_list_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  alle_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // track which slots hold data, to aim deletes and sets at live nodes
  always @(posedge clk) begin
    if (!rst_n) begin
      live_hint <= '0;
    end else if (out_valid) begin
      live_hint[out_item.node_out] <= out_item.node_in_use;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{operation: op, node_index: idx, value_in: v};
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [IDX_W-1:0] any_live();
    logic [IDX_W-1:0] s;
    s = IDX_W'($urandom);
    for (int k = 0; k < CAPACITY; k++) begin
      if (s != 0 && live_hint[s]) return s;
      s = s + 1'b1;
    end
    return IDX_W'($urandom);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return D_MIN;
      1:       return D_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item(input int n);
    int w [7];
    int r;
    int k;
    int u;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    // grow toward a full table, mix, then drain
    if ((n % 240) < 90) begin
      w = '{30, 20, 30, 6, 6, 5, 3};
    end else if ((n % 240) < 150) begin
      w = '{15, 10, 15, 25, 15, 15, 5};
    end else begin
      w = '{5, 5, 5, 60, 10, 12, 3};
    end
    r = $urandom_range(0, 99);
    k = 0;
    while (k < 6 && r >= w[k]) begin
      r = r - w[k];
      k++;
    end
    u = $urandom_range(0, 99);
    case (k)
      0: begin
        op  = OP_INS_AFTER;
        idx = (u < 15) ? '0 : (u < 85) ? any_live() : IDX_W'($urandom);
      end
      1: begin
        op  = OP_INS_FRONT;
        idx = IDX_W'($urandom);
      end
      2: begin
        op  = OP_INS_BACK;
        idx = IDX_W'($urandom);
      end
      3: begin
        op  = OP_DELETE;
        idx = (u < 80) ? any_live() : IDX_W'($urandom);
      end
      4: begin
        op  = OP_SET_DATA;
        idx = (u < 80) ? any_live() : IDX_W'($urandom);
      end
      5: begin
        op  = OP_READ_NODE;
        idx = (u < 50) ? any_live() : IDX_W'($urandom);
      end
      default: begin
        op  = (u < 50) ? OP_RSVD_6 : OP_RSVD_7;
        idx = IDX_W'($urandom);
      end
    endcase
    send_item(op, idx, pick_value());
  endtask

  initial begin
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_item  <= '0;
    idle_pct = 21;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_READ_NODE, 6'd0, 32'sd1);
    send_item(OP_DELETE, 6'd5, 32'sd0);
    send_item(OP_DELETE, 6'd0, 32'sd0);
    send_item(OP_INS_AFTER, 6'd7, 32'sd3);
    send_item(OP_SET_DATA, 6'd0, 32'sd4);
    send_item(OP_SET_DATA, 6'd9, 32'sd5);
    send_item(OP_RSVD_6, 6'd63, D_MAX);
    send_item(OP_RSVD_7, 6'd0, D_MIN);
    send_item(OP_INS_BACK, 6'd63, D_MIN);
    send_item(OP_INS_FRONT, 6'd0, D_MAX);
    send_item(OP_INS_AFTER, 6'd0, 32'sd0);
    send_item(OP_INS_AFTER, 6'd1, -32'sd1);
    send_item(OP_READ_NODE, 6'd63, 32'sd0);
    send_item(OP_SET_DATA, 6'd4, 32'sh5A5A_A5A5);
    send_item(OP_READ_NODE, 6'd4, 32'sd0);
    send_item(OP_DELETE, 6'd3, 32'sd0);
    send_item(OP_DELETE, 6'd4, 32'sd0);
    send_item(OP_DELETE, 6'd3, 32'sd0);
    send_item(OP_INS_BACK, 6'd0, 32'sh1234_5678);
    send_item(OP_DELETE, 6'd1, 32'sd0);
    send_item(OP_DELETE, 6'd2, 32'sd0);
    send_item(OP_DELETE, 6'd4, 32'sd0);
    send_item(OP_DELETE, 6'd2, 32'sd0);
    send_item(OP_INS_AFTER, 6'd63, -32'sd1);
    send_item(OP_READ_NODE, 6'd4, 32'sd0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) idle_pct = 56;
      if (n == 2 * N_RANDOM / 3) idle_pct = 0;
      random_item(n);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[array_linked_list_engine.f]
src/alle_pkg.sv
src/alle_ctrl.sv
src/alle_dp.sv
src/array_linked_list_engine.sv
sim/alle_checker.sv
sim/tb_array_linked_list_engine.sv
